// ----- src/uart_register_file_with_rx_fifo_top_defines.svh -----
// Assertion macros shared by the UART register file RTL.
`ifndef UART_REGISTER_FILE_WITH_RX_FIFO_TOP_DEFINES_SVH
`define UART_REGISTER_FILE_WITH_RX_FIFO_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UART_RF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("uart_rf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UART_RF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("uart_rf: next-cycle check failed");

`endif

// ----- src/uart_rf_pkg.sv -----
// Package with the types and constants of the UART register file.
`default_nettype none
package uart_rf_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 16;
	localparam int unsigned CFG_IDX_W      = 1;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_RX    = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_RBR_THR = 3'd0,
		REG_IER     = 3'd1,
		REG_IIR_FCR = 3'd2,
		REG_LCR     = 3'd3,
		REG_MCR     = 3'd4,
		REG_LSR     = 3'd5,
		REG_MSR     = 3'd6,
		REG_SCR     = 3'd7
	} reg_addr_t;

	localparam logic [CFG_IDX_W-1:0] CFG_LSR_FIXED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSR_VALUE = 1'b1;

	localparam logic [7:0] LSR_FIXED_RST = 8'h60;
	localparam logic [7:0] MSR_VALUE_RST = 8'hB0;

	localparam int unsigned LCR_DLAB_BIT   = 7;
	localparam int unsigned FCR_ENABLE_BIT = 0;
	localparam int unsigned FCR_RXCLR_BIT  = 1;
	localparam int unsigned FCR_TXCLR_BIT  = 2;
	localparam int unsigned IER_RX_BIT     = 0;
	localparam int unsigned IER_TX_BIT     = 1;

	localparam logic [7:0] IIR_RX_DATA   = 8'b0000_0100;
	localparam logic [7:0] IIR_THR_EMPTY = 8'b0000_0010;
	localparam logic [7:0] IIR_NONE      = 8'b0000_0001;
	localparam logic [7:0] IIR_FIFO_BITS = 8'b1100_0000;

endpackage
`default_nettype wire

// ----- src/uart_register_file_with_rx_fifo_top.sv -----
// A result appears in the output register in the cycle after its transaction is accepted.
// One transaction per cycle unless stalled; the FIFO memory has one write and one read port.
// The received-byte memory is read at the read index on every accepted transaction.
// Reset clears state registers, indices and per-entry valid bits at once; no clearing pass.
// The interrupt line reads high from the first accepted command until the first update tick.
// Register file and receive FIFO of a simplified 16550 UART.
`default_nettype none
`include "uart_register_file_with_rx_fifo_top_defines.svh"
module uart_register_file_with_rx_fifo_top #(
	parameter int unsigned FIFO_DEPTH = uart_rf_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [uart_rf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [1:0]                       cmd,
	input  wire logic [2:0]                       addr,
	input  wire logic [7:0]                       data_in,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [7:0]                            rdata,
	output logic                                  tx_valid,
	output logic [7:0]                            tx_byte,
	output logic                                  irq,
	output logic                                  error
);

	localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);

	// Configuration registers.
	logic [7:0] lsr_fixed_q, msr_value_q;

	// Architectural registers.
	logic [7:0] dll_q, dlm_q, lcr_q, mcr_q, scr_q, ier_q, fcr_q, iir_q;
	logic       thr_empty_q;
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	logic [7:0] dll_d, dlm_d, lcr_d, mcr_d, scr_d, ier_d, fcr_d, iir_d;
	logic       thr_empty_d;
	logic [PW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;

	// Receive FIFO memory with per-entry valid bits.
	logic [7:0] rx_mem [FIFO_DEPTH];
	logic [FIFO_DEPTH-1:0] rx_vld_q;
	logic       push;

	// Result stage.
	logic [7:0] rdata_s1, rd_data_s1, tx_byte_s1;
	logic       pop_s1, rd_vld_s1, tx_valid_s1, irq_s1, error_s1;
	logic [7:0] rdata_c, tx_byte_c;
	logic       pop_c, tx_valid_c, error_c;

	logic acc;
	logic dlab;
	logic rx_int, tx_int;
	uart_rf_pkg::cmd_t      cmd_c;
	uart_rf_pkg::reg_addr_t addr_c;

	assign in_stall = out_valid && out_stall;
	assign acc      = in_valid && !in_stall;
	assign dlab     = lcr_q[uart_rf_pkg::LCR_DLAB_BIT];
	assign cmd_c    = uart_rf_pkg::cmd_t'(cmd);
	assign addr_c   = uart_rf_pkg::reg_addr_t'(addr);
	assign push     = acc && (cmd_c == uart_rf_pkg::CMD_RX);

	always_comb begin
		dll_d       = dll_q;
		dlm_d       = dlm_q;
		lcr_d       = lcr_q;
		mcr_d       = mcr_q;
		scr_d       = scr_q;
		ier_d       = ier_q;
		fcr_d       = fcr_q;
		iir_d       = iir_q;
		thr_empty_d = thr_empty_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		rdata_c     = 8'h00;
		pop_c       = 1'b0;
		tx_valid_c  = 1'b0;
		tx_byte_c   = 8'h00;
		error_c     = 1'b0;
		rx_int      = 1'b0;
		tx_int      = 1'b0;
		unique case (cmd_c)
			uart_rf_pkg::CMD_READ: begin
				unique case (addr_c)
					uart_rf_pkg::REG_RBR_THR: begin
						if (dlab) begin
							rdata_c = dll_q;
						end else begin
							// The byte comes from the registered memory read port in the next cycle.
							pop_c = 1'b1;
							if (count_q != '0) begin
								head_d  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
								count_d = count_q - 1'b1;
							end
						end
					end
					uart_rf_pkg::REG_IER:     rdata_c = dlab ? dlm_q : ier_q;
					uart_rf_pkg::REG_IIR_FCR: begin
						rdata_c     = iir_q;
						thr_empty_d = 1'b0;
					end
					uart_rf_pkg::REG_LCR:     rdata_c = lcr_q;
					uart_rf_pkg::REG_MCR:     rdata_c = mcr_q;
					uart_rf_pkg::REG_LSR:     rdata_c = lsr_fixed_q | {7'd0, count_q != '0};
					uart_rf_pkg::REG_MSR:     rdata_c = msr_value_q;
					uart_rf_pkg::REG_SCR:     rdata_c = scr_q;
					default:                  rdata_c = 8'h00;
				endcase
			end
			uart_rf_pkg::CMD_WRITE: begin
				unique case (addr_c)
					uart_rf_pkg::REG_RBR_THR: begin
						if (dlab) begin
							dll_d = data_in;
						end else begin
							tx_valid_c  = 1'b1;
							tx_byte_c   = data_in;
							thr_empty_d = 1'b1;
						end
					end
					uart_rf_pkg::REG_IER: begin
						if (dlab) begin
							dlm_d = data_in;
						end else begin
							ier_d = data_in;
						end
					end
					uart_rf_pkg::REG_IIR_FCR: fcr_d = data_in;
					uart_rf_pkg::REG_LCR:     lcr_d = data_in;
					uart_rf_pkg::REG_MCR:     mcr_d = data_in;
					uart_rf_pkg::REG_SCR:     scr_d = data_in;
					default:                  error_c = 1'b1;
				endcase
			end
			uart_rf_pkg::CMD_RX: begin
				tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
				if (count_q < DEPTH_C) begin
					count_d = count_q + 1'b1;
				end else begin
					// Full: the new byte replaces the oldest one.
					head_d = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
				end
			end
			uart_rf_pkg::CMD_TICK: begin
				fcr_d[uart_rf_pkg::FCR_TXCLR_BIT] = 1'b0;
				if (fcr_q[uart_rf_pkg::FCR_RXCLR_BIT]) begin
					head_d = tail_q;
					count_d = '0;
					fcr_d[uart_rf_pkg::FCR_RXCLR_BIT] = 1'b0;
				end
				rx_int = (count_d != '0) && ier_q[uart_rf_pkg::IER_RX_BIT];
				tx_int = thr_empty_q && ier_q[uart_rf_pkg::IER_TX_BIT];
				if (rx_int) begin
					iir_d = uart_rf_pkg::IIR_RX_DATA;
				end else if (tx_int) begin
					iir_d = uart_rf_pkg::IIR_THR_EMPTY;
				end else begin
					iir_d = uart_rf_pkg::IIR_NONE;
				end
				if (fcr_q[uart_rf_pkg::FCR_ENABLE_BIT]) begin
					iir_d = iir_d | uart_rf_pkg::IIR_FIFO_BITS;
				end
			end
			default: rdata_c = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsr_fixed_q <= uart_rf_pkg::LSR_FIXED_RST;
			msr_value_q <= uart_rf_pkg::MSR_VALUE_RST;
		end else if (cfg_we) begin
			if (cfg_index == uart_rf_pkg::CFG_LSR_FIXED) begin
				lsr_fixed_q <= cfg_data;
			end
			if (cfg_index == uart_rf_pkg::CFG_MSR_VALUE) begin
				msr_value_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dll_q       <= '0;
			dlm_q       <= '0;
			lcr_q       <= '0;
			mcr_q       <= '0;
			scr_q       <= '0;
			ier_q       <= '0;
			fcr_q       <= '0;
			iir_q       <= '0;
			thr_empty_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rx_vld_q    <= '0;
		end else if (acc) begin
			dll_q       <= dll_d;
			dlm_q       <= dlm_d;
			lcr_q       <= lcr_d;
			mcr_q       <= mcr_d;
			scr_q       <= scr_d;
			ier_q       <= ier_d;
			fcr_q       <= fcr_d;
			iir_q       <= iir_d;
			thr_empty_q <= thr_empty_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			if (push) begin
				rx_vld_q[tail_q] <= 1'b1;
			end
		end
	end

	// FIFO memory: one write port at the write index, one registered read port at the read index.
	always_ff @(posedge clk) begin
		if (push) begin
			rx_mem[tail_q] <= data_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_data_s1 <= rx_mem[head_q];
			rd_vld_s1  <= rx_vld_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (acc) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1    <= rdata_c;
			pop_s1      <= pop_c;
			tx_valid_s1 <= tx_valid_c;
			tx_byte_s1  <= tx_byte_c;
			irq_s1      <= !iir_d[0];
			error_s1    <= error_c;
		end
	end

	// An entry that was never written reads as zero.
	assign rdata    = pop_s1 ? (rd_vld_s1 ? rd_data_s1 : 8'h00) : rdata_s1;
	assign tx_valid = tx_valid_s1;
	assign tx_byte  = tx_byte_s1;
	assign irq      = irq_s1;
	assign error    = error_s1;

	`UART_RF_ASSERT_SAME(a_tx_excl, clk, arst_n, out_valid && tx_valid, !error && (rdata == 8'h00))
	`UART_RF_ASSERT_NEXT(a_thr_send, clk, arst_n, acc && (cmd == uart_rf_pkg::CMD_WRITE) && (addr == uart_rf_pkg::REG_RBR_THR) && !dlab, out_valid && tx_valid && thr_empty_q)
	`UART_RF_ASSERT_NEXT(a_push_count, clk, arst_n, push && (count_q < DEPTH_C), count_q == $past(count_q) + 1'b1)

endmodule
`default_nettype wire
